// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PKC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- design/pkc_pkg.sv -----
// ---------------------------------------------------------------------------
// pkc_pkg
// Widths, operation codes and shared types of the kinematics converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pkc_pkg;

  // Value format: signed fixed point with VW total and FB fraction bits.
  localparam int VW     = 48;
  localparam int FB     = 24;
  localparam int HALF   = VW / 2;
  localparam int AMU_W  = 25;
  localparam int A_W    = 8;
  localparam int Z_W    = 8;
  localparam int OP_W   = 3;

  // Derived datapath widths.
  localparam int MW      = AMU_W + A_W;           // particle mass
  localparam int ZXW     = VW + Z_W;              // |Z| * |x|
  localparam int KW      = VW + A_W;              // x * A
  localparam int XXW     = 2 * VW;                // x squared
  localparam int KPW     = VW - 1 + HALF;         // partial products of k*(k+2M)
  localparam int SQIN_W  = XXW + 1;               // widest square root argument
  localparam int SQ_CELLS = (SQIN_W + 1) / 2;     // one root bit per cell
  localparam int SQA_W   = 2 * SQ_CELLS;
  localparam int RTW     = SQ_CELLS;
  localparam int SRW     = RTW + 3;
  localparam int ZH      = ZXW / 2;
  localparam int SW5     = FB + 1;                // root width when beta is valid
  localparam int NW      = ZXW + SW5;             // widest dividend
  localparam int DW      = RTW;                   // widest divisor
  localparam int QW      = VW;                    // quotient bits worked out
  localparam int RW      = DW + 1;

  localparam logic [AMU_W-1:0] AMU_RESET = AMU_W'(15627876);
  localparam logic [VW-1:0]    VMAX      = {1'b0, {(VW - 1){1'b1}}};
  localparam logic [VW-1:0]    VMIN_MAG  = {1'b1, {(VW - 1){1'b0}}};

  // Register index of the atomic mass unit energy.
  localparam logic CFG_AMU = 1'b0;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_R2P  = 3'd0;
  localparam logic [OP_W-1:0] OP_P2B  = 3'd1;
  localparam logic [OP_W-1:0] OP_B2P  = 3'd2;
  localparam logic [OP_W-1:0] OP_P2E  = 3'd3;
  localparam logic [OP_W-1:0] OP_E2P  = 3'd4;
  localparam logic [OP_W-1:0] OP_MASS = 3'd5;

  // Item data that travels beside the square root chain.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            bad;
    logic [VW-1:0]   xmag;
    logic            xneg;
    logic [FB-1:0]   bmag;
    logic [A_W-1:0]  a;
    logic [MW-1:0]   m;
    logic [ZXW-1:0]  zx;
    logic            ksat;
  } sq_side_t;

  // Item flags that travel beside the divider chain.
  typedef struct packed {
    logic bad;
    logic neg;
    logic ksat;
    logic ovf;
  } dv_side_t;

endpackage

// ----- design/pkc_front.sv -----
// ---------------------------------------------------------------------------
// pkc_front
// Operand decode, products and selection of the square root argument.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkc_front import pkc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [VW-1:0]     prim_i,
  input  logic [VW-1:0]     beta_i,
  input  logic [A_W-1:0]    a_i,
  input  logic [Z_W-1:0]    z_i,
  input  logic [AMU_W-1:0]  amu_i,
  output logic              vld_o,
  output logic [SQA_W-1:0]  arg_o,
  output sq_side_t          side_o
);

  // First stage signals.
  logic              xneg, bbad;
  logic [VW-1:0]     xmag;
  logic [Z_W-1:0]    zmag;
  sq_side_t          side1_d, side1_q, side2_d, side2_q, side3_q;
  logic [KW-1:0]     k1_d, k1_q;
  logic [VW+HALF-1:0] p0_d, p0_q, p1_d, p1_q;
  logic [2*FB-1:0]   bb_d, bb1_q, bb2_q;
  logic              v1_q, v2_q, v3_q, v4_q;

  // Second stage signals.
  logic [XXW-1:0]    xx_q;
  logic [2*MW-1:0]   mm_q;
  logic [VW-2:0]     k2_q;
  logic [VW-1:0]     kk_q;

  // Third stage signals.
  logic [KPW-1:0]    kp0_q, kp1_q;
  logic [SQIN_W-1:0] sum_q;
  logic [2*FB:0]     arg25_q;
  logic [SQIN_W-1:0] arg_d;

  // Magnitudes, range checks and the first products.
  always_comb begin
    xneg = prim_i[VW-1];
    xmag = xneg ? (~prim_i + 1'b1) : prim_i;
    zmag = z_i[Z_W-1] ? (~z_i + 1'b1) : z_i;
    bbad = beta_i[VW-1] | (beta_i == '0) | (|beta_i[VW-2:FB]);
    k1_d = KW'(xmag) * KW'(a_i);
    p0_d = (VW+HALF)'(xmag) * (VW+HALF)'(xmag[HALF-1:0]);
    p1_d = (VW+HALF)'(xmag) * (VW+HALF)'(xmag[VW-1:HALF]);
    bb_d = (2*FB)'(beta_i[FB-1:0]) * (2*FB)'(beta_i[FB-1:0]);
    side1_d.op   = op_i;
    side1_d.xmag = xmag;
    side1_d.xneg = xneg;
    side1_d.bmag = beta_i[FB-1:0];
    side1_d.a    = a_i;
    side1_d.m    = MW'(amu_i) * MW'(a_i);
    side1_d.zx   = ZXW'(xmag) * ZXW'(zmag);
    side1_d.ksat = 1'b0;
    case (op_i)
      OP_R2P:  side1_d.bad = 1'b0;
      OP_P2B:  side1_d.bad = (a_i == '0) | xneg;
      OP_B2P:  side1_d.bad = (a_i == '0) | bbad;
      OP_P2E:  side1_d.bad = (a_i == '0) | xneg;
      OP_E2P:  side1_d.bad = (a_i == '0) | xneg | (xmag == '0);
      OP_MASS: side1_d.bad = bbad;
      default: side1_d.bad = 1'b1;
    endcase
  end

  // Second stage side data with the saturation flag of x * A.
  always_comb begin
    side2_d      = side1_q;
    side2_d.ksat = |k1_q[KW-1:VW-1];
  end

  // Argument of the square root for each operation.
  always_comb begin
    case (side3_q.op)
      OP_P2B, OP_P2E:  arg_d = sum_q;
      OP_B2P, OP_MASS: arg_d = SQIN_W'(arg25_q);
      OP_E2P:          arg_d = SQIN_W'(kp0_q) + (SQIN_W'(kp1_q) << HALF);
      default:         arg_d = '0;
    endcase
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage data.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side1_d;
      k1_q    <= k1_d;
      p0_q    <= p0_d;
      p1_q    <= p1_d;
      bb1_q   <= bb_d;

      side2_q <= side2_d;
      xx_q    <= XXW'(p0_q) + (XXW'(p1_q) << HALF);
      mm_q    <= (2*MW)'(side1_q.m) * (2*MW)'(side1_q.m);
      k2_q    <= k1_q[VW-2:0];
      kk_q    <= VW'(k1_q[VW-2:0]) + (VW'(side1_q.m) << 1);
      bb2_q   <= bb1_q;

      side3_q <= side2_q;
      kp0_q   <= KPW'(k2_q) * KPW'(kk_q[HALF-1:0]);
      kp1_q   <= KPW'(k2_q) * KPW'(kk_q[VW-1:HALF]);
      sum_q   <= SQIN_W'(xx_q) + SQIN_W'(mm_q);
      arg25_q <= {1'b1, {(2*FB){1'b0}}} - {1'b0, bb2_q};

      side_o  <= side3_q;
      arg_o   <= SQA_W'(arg_d);
    end
  end

  assign vld_o = v4_q;

endmodule

// ----- design/pkc_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// pkc_sqrt_cell
// One cell of the square root chain: settles one root bit per cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkc_sqrt_cell import pkc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [SQA_W-1:0] arg_i,
  input  logic [RTW-1:0]   root_i,
  input  logic [SRW-1:0]   rem_i,
  input  sq_side_t         side_i,
  output logic             vld_o,
  output logic [SQA_W-1:0] arg_o,
  output logic [RTW-1:0]   root_o,
  output logic [SRW-1:0]   rem_o,
  output sq_side_t         side_o
);

  logic [SRW-1:0] rem_sh, trial, rem_d;
  logic [RTW-1:0] root_d;
  logic           ge;

  // Bring down two argument bits and try the next root bit.
  always_comb begin
    rem_sh = {rem_i[SRW-3:0], arg_i[SQA_W-1 -: 2]};
    trial  = SRW'({root_i, 2'b01});
    ge     = rem_sh >= trial;
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
    root_d = {root_i[RTW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      arg_o  <= {arg_i[SQA_W-3:0], 2'b00};
      root_o <= root_d;
      rem_o  <= rem_d;
      side_o <= side_i;
    end
  end

endmodule

// ----- design/pkc_mid.sv -----
// ---------------------------------------------------------------------------
// pkc_mid
// Forms dividend and divisor from the root and checks quotient overflow.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkc_mid import pkc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [RTW-1:0]  root_i,
  input  sq_side_t        side_i,
  output logic            vld_o,
  output logic [QW-1:0]   nlo_o,
  output logic [RW-1:0]   rem_o,
  output logic [DW-1:0]   d_o,
  output dv_side_t        side_o
);

  logic                 v1_q, v2_q, v3_q;
  sq_side_t             side1_q;
  logic [RTW-1:0]       s_q;
  logic [ZH+SW5-1:0]    zp0_q, zp1_q;
  logic [MW+FB-1:0]     mb_q;
  logic [RTW-1:0]       em_q;
  logic [NW-1:0]        n_d, n_q;
  logic [DW-1:0]        d_d, d_q;
  dv_side_t             ds_d, ds_q, ds3_d;

  // Dividend and divisor for each operation.
  always_comb begin
    n_d = '0;
    d_d = DW'(1);
    case (side1_q.op)
      OP_R2P: n_d = NW'(side1_q.zx);
      OP_P2B: begin
        n_d = NW'(side1_q.xmag) << FB;
        d_d = (s_q == '0) ? DW'(1) : DW'(s_q);
      end
      OP_B2P: begin
        n_d = NW'(mb_q);
        d_d = DW'(s_q);
      end
      OP_P2E: begin
        n_d = NW'(em_q);
        d_d = DW'(side1_q.a);
      end
      OP_E2P: n_d = NW'(s_q);
      OP_MASS: begin
        n_d = NW'(zp0_q) + (NW'(zp1_q) << ZH);
        d_d = DW'(side1_q.bmag);
      end
      default: n_d = '0;
    endcase
    ds_d.bad  = side1_q.bad | ((side1_q.op == OP_P2B) & (s_q == '0));
    ds_d.neg  = (side1_q.op == OP_MASS) & side1_q.xneg;
    ds_d.ksat = (side1_q.op == OP_E2P) & side1_q.ksat;
    ds_d.ovf  = 1'b0;
  end

  // The quotient reaches 2^QW exactly when the upper dividend part is not below the divisor.
  always_comb begin
    ds3_d     = ds_q;
    ds3_d.ovf = DW'(n_q[NW-1:QW]) >= d_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Products with the root.
      side1_q <= side_i;
      s_q     <= root_i;
      zp0_q   <= (ZH+SW5)'(side_i.zx[ZH-1:0]) * (ZH+SW5)'(root_i[SW5-1:0]);
      zp1_q   <= (ZH+SW5)'(side_i.zx[ZXW-1:ZH]) * (ZH+SW5)'(root_i[SW5-1:0]);
      mb_q    <= (MW+FB)'(side_i.m) * (MW+FB)'(side_i.bmag);
      em_q    <= root_i - RTW'(side_i.m);
      // Operand selection.
      n_q     <= n_d;
      d_q     <= d_d;
      ds_q    <= ds_d;
      // Divider start values.
      nlo_o   <= n_q[QW-1:0];
      rem_o   <= RW'(n_q[NW-1:QW]);
      d_o     <= d_q;
      side_o  <= ds3_d;
    end
  end

  assign vld_o = v3_q;

endmodule

// ----- design/pkc_div_cell.sv -----
// ---------------------------------------------------------------------------
// pkc_div_cell
// One cell of the restoring divider chain: settles one quotient bit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkc_div_cell import pkc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [QW-1:0]  nlo_i,
  input  logic [RW-1:0]  rem_i,
  input  logic [DW-1:0]  d_i,
  input  logic [QW-1:0]  q_i,
  input  dv_side_t       side_i,
  output logic           vld_o,
  output logic [QW-1:0]  nlo_o,
  output logic [RW-1:0]  rem_o,
  output logic [DW-1:0]  d_o,
  output logic [QW-1:0]  q_o,
  output dv_side_t       side_o
);

  logic [RW-1:0] rem_sh, rem_d;
  logic          ge;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    rem_sh = {rem_i[RW-2:0], nlo_i[QW-1]};
    ge     = rem_sh >= RW'(d_i);
    rem_d  = ge ? (rem_sh - RW'(d_i)) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nlo_o  <= {nlo_i[QW-2:0], 1'b0};
      rem_o  <= rem_d;
      d_o    <= d_i;
      q_o    <= {q_i[QW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

// ----- design/particle_kinematics_converter.sv -----
// ---------------------------------------------------------------------------
// particle_kinematics_converter
// Relativistic rigidity, momentum, beta, energy and mass conversions.
// ---------------------------------------------------------------------------
// Usage: a request is one transfer on the input channel (in_valid_i and
// in_ready_o) carrying the operation, the primary value, beta, the mass
// number and the charge. Every request gives exactly one result transfer
// on the output channel (out_valid_o and out_ready_i), in request order.
// On its way to the output a request passes four front stages, 49 square
// root cells, three operand stages, 48 divider cells and the output
// register. Throughput is one request per cycle unless the chain holds;
// the square root and divider chains each settle one bit per cell, so
// every cell holds a different request. When the receiver stalls, the
// result waits in the output register and one more result lands in a
// skid register; only then does in_ready_o drop and the whole chain
// hold. Reset empties the pipeline and loads the atomic mass unit energy
// with its default. The user must write the energy register over the APB
// port only while no request is in flight; the block does not enforce it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_kinematics_converter import pkc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Request channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OP_W-1:0]  req_type_i,
  input  logic [VW-1:0]    primary_value_i,
  input  logic [VW-1:0]    beta_value_i,
  input  logic [A_W-1:0]   mass_number_i,
  input  logic [Z_W-1:0]   charge_i,
  // Result channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [VW-1:0]    result_value_o,
  output logic             result_valid_o,
  // Configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic             en;
  logic [AMU_W-1:0] amu_q;

  // Square root chain wiring.
  logic             sq_vld  [SQ_CELLS+1];
  logic [SQA_W-1:0] sq_arg  [SQ_CELLS+1];
  logic [RTW-1:0]   sq_root [SQ_CELLS+1];
  logic [SRW-1:0]   sq_rem  [SQ_CELLS+1];
  sq_side_t         sq_side [SQ_CELLS+1];

  // Divider chain wiring.
  logic             dv_vld  [QW+1];
  logic [QW-1:0]    dv_nlo  [QW+1];
  logic [RW-1:0]    dv_rem  [QW+1];
  logic [DW-1:0]    dv_d    [QW+1];
  logic [QW-1:0]    dv_q    [QW+1];
  dv_side_t         dv_side [QW+1];

  // Final result and output buffering.
  logic [VW-1:0]    fin_val, fin_mag, q_last;
  logic             fin_ok;
  dv_side_t         s_last;
  logic             out_vld_q, sk_vld_q, out_ok_q, sk_ok_q;
  logic [VW-1:0]    out_val_q, sk_val_q;
  logic             take, push;

  // The pipeline moves whenever the skid register is empty.
  assign en         = !sk_vld_q;
  assign in_ready_o = en;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_AMU) ? 32'(amu_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amu_q <= AMU_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == CFG_AMU)) begin
      amu_q <= pwdata[AMU_W-1:0];
    end
  end

  pkc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .op_i   (req_type_i),
    .prim_i (primary_value_i),
    .beta_i (beta_value_i),
    .a_i    (mass_number_i),
    .z_i    (charge_i),
    .amu_i  (amu_q),
    .vld_o  (sq_vld[0]),
    .arg_o  (sq_arg[0]),
    .side_o (sq_side[0])
  );

  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;

  // Square root cells.
  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
    pkc_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sq_vld[i]),
      .arg_i  (sq_arg[i]),
      .root_i (sq_root[i]),
      .rem_i  (sq_rem[i]),
      .side_i (sq_side[i]),
      .vld_o  (sq_vld[i+1]),
      .arg_o  (sq_arg[i+1]),
      .root_o (sq_root[i+1]),
      .rem_o  (sq_rem[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  pkc_mid u_mid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_vld[SQ_CELLS]),
    .root_i (sq_root[SQ_CELLS]),
    .side_i (sq_side[SQ_CELLS]),
    .vld_o  (dv_vld[0]),
    .nlo_o  (dv_nlo[0]),
    .rem_o  (dv_rem[0]),
    .d_o    (dv_d[0]),
    .side_o (dv_side[0])
  );

  assign dv_q[0] = '0;

  // Divider cells.
  for (genvar j = 0; j < QW; j++) begin : g_div
    pkc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dv_vld[j]),
      .nlo_i  (dv_nlo[j]),
      .rem_i  (dv_rem[j]),
      .d_i    (dv_d[j]),
      .q_i    (dv_q[j]),
      .side_i (dv_side[j]),
      .vld_o  (dv_vld[j+1]),
      .nlo_o  (dv_nlo[j+1]),
      .rem_o  (dv_rem[j+1]),
      .d_o    (dv_d[j+1]),
      .q_o    (dv_q[j+1]),
      .side_o (dv_side[j+1])
    );
  end

  // Saturation, sign and the invalid case.
  always_comb begin
    s_last  = dv_side[QW];
    q_last  = dv_q[QW];
    fin_ok  = !s_last.bad;
    fin_mag = (s_last.ovf || (q_last > VMIN_MAG)) ? VMIN_MAG : q_last;
    if (s_last.bad) begin
      fin_val = '0;
    end else if (s_last.ksat) begin
      fin_val = VMAX;
    end else if (s_last.neg && (s_last.ovf || (q_last != '0))) begin
      fin_val = ~fin_mag + 1'b1;
    end else begin
      fin_val = (s_last.ovf || (q_last > VMAX)) ? VMAX : q_last;
    end
  end

  // Output register with a skid register behind it.
  assign take = out_vld_q & out_ready_i;
  assign push = en & dv_vld[QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sk_vld_q  <= 1'b0;
    end else if (sk_vld_q) begin
      if (take) begin
        sk_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld_q || take) begin
        out_vld_q <= 1'b1;
      end else begin
        sk_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_vld_q) begin
      if (take) begin
        out_val_q <= sk_val_q;
        out_ok_q  <= sk_ok_q;
      end
    end else if (push) begin
      if (!out_vld_q || take) begin
        out_val_q <= fin_val;
        out_ok_q  <= fin_ok;
      end else begin
        sk_val_q <= fin_val;
        sk_ok_q  <= fin_ok;
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign result_value_o = out_val_q;
  assign result_valid_o = out_ok_q;

endmodule

// ----- design/pkc_checker.sv -----
// ---------------------------------------------------------------------------
// pkc_checker
// Port-level checks of the kinematics converter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pkc_checker import pkc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [VW-1:0]    result_value_o,
  input logic             result_valid_o
);

  // A stalled result stays put until its transfer.
  `PKC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o) && $stable(result_valid_o), "result changed while stalled")

  // A result flagged invalid always carries zero.
  `PKC_ASSERT(a_bad_zero, out_valid_o && !result_valid_o |-> result_value_o == '0, "invalid result is not zero")

  // Input is only held back while a result is waiting.
  `PKC_ASSERT(a_ready_free, !out_valid_o |-> in_ready_o, "input blocked with empty output")

  // A clock edge under reset leaves no result on the output.
  `PKC_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_o, "result visible during reset")

endmodule

bind particle_kinematics_converter pkc_checker u_pkc_checker (.*);
